### rtl/core/pgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pgc_pkg;

  localparam int MaxVertices = 16;
  localparam int CoordW      = 32;
  localparam int DiffW       = CoordW + 1;
  localparam int ProdW       = 2 * CoordW;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int CntW        = $clog2(MaxVertices + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_DIFF,
    ST_MUL_P,
    ST_MUL_Q,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
  } in_beat_t;

  typedef struct packed {
    logic inside_res;
    logic stop_command;
    logic vertices_dropped;
  } out_beat_t;

endpackage

`default_nettype wire

### rtl/core/polygon_geofence_check.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_beat  (operation, coord_x, coord_y)
// out_     output     out_valid / out_ready  out_beat (inside_res, stop_command,
//                                                     vertices_dropped)
//
// A query walks the polygon edge by edge: one shared 32x32 multiplier forms the
// two cross products of each edge in turn, and the vertex store is read through
// one registered port, one vertex per edge.
// Reset (rst_n, synchronous, active low) empties the polygon and clears the
// dropped flag; the vertex store itself is not cleared.
// A finished result waits in the output register; clears and appends are still
// taken meanwhile, a new query holds its result until the old one is taken.

module polygon_geofence_check (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  pgc_pkg::in_beat_t     in_beat,
  output logic                  out_valid,
  input  wire                   out_ready,
  output pgc_pkg::out_beat_t    out_beat
);

  import pgc_pkg::*;

  // Vertex store: one write port (append), one registered read port (query walk).
  logic [CoordW-1:0] mem_x [MaxVertices];
  logic [CoordW-1:0] mem_y [MaxVertices];

  state_t state_r, state_nxt;

  logic [CntW-1:0] count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            inside_r, inside_nxt;

  // Query position, held for the whole walk.
  logic signed [CoordW-1:0] px_r, px_nxt;
  logic signed [CoordW-1:0] py_r, py_nxt;

  // Vertex j (the one before i) and the registered read data (vertex i).
  logic signed [CoordW-1:0] xj_r, xj_nxt;
  logic signed [CoordW-1:0] yj_r, yj_nxt;
  logic signed [CoordW-1:0] rd_x_r;
  logic signed [CoordW-1:0] rd_y_r;

  // Edge operands as magnitude and sign: a=px-xi, b=yj-yi, c=xj-xi, d=py-yi.
  logic [CoordW-1:0] a_mag_r, b_mag_r, c_mag_r, d_mag_r;
  logic [CoordW-1:0] a_mag_nxt, b_mag_nxt, c_mag_nxt, d_mag_nxt;
  logic              a_neg_r, b_neg_r, c_neg_r, d_neg_r;
  logic              a_neg_nxt, b_neg_nxt, c_neg_nxt, d_neg_nxt;
  logic              cross_r, cross_nxt;
  logic              dy_pos_r, dy_pos_nxt;

  logic [ProdW-1:0] p_r, p_nxt;
  logic [ProdW-1:0] q_r, q_nxt;

  logic            out_valid_r, out_valid_nxt;
  out_beat_t       out_beat_r, out_beat_nxt;

  // Control decode
  logic            in_acc;
  logic            is_query;
  logic            is_append;
  logic            is_clear;
  logic            last_edge;
  logic            load_out;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] count_m1;

  // Shared multiplier
  logic [CoordW-1:0] mul_a;
  logic [CoordW-1:0] mul_b;
  logic [ProdW-1:0]  mul_p;

  // Edge difference terms
  logic signed [DiffW-1:0] dif_a, dif_b, dif_c, dif_d;

  // Compare terms
  logic p_neg, q_neg, p_gt_q, p_eq_q, edge_hit;

  function automatic logic [CoordW-1:0] mag_of(input logic signed [DiffW-1:0] v);
    logic signed [DiffW-1:0] n;
    n = -v;
    return v[DiffW-1] ? n[CoordW-1:0] : v[CoordW-1:0];
  endfunction

  assign in_acc    = in_valid && in_ready;
  assign is_query  = in_beat.operation == OP_QUERY;
  assign is_append = in_beat.operation == OP_APPEND;
  assign is_clear  = in_beat.operation == OP_CLEAR;
  assign count_m1  = count_r - CntW'(1);
  assign last_edge = {1'b0, idx_r} == count_m1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_nxt = (count_r == '0) ? ST_DONE : ST_PRIME;
        end
      end
      ST_PRIME: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MUL_P;
      ST_MUL_P: state_nxt = ST_MUL_Q;
      ST_MUL_Q: state_nxt = ST_CMP;
      ST_CMP:   state_nxt = last_edge ? ST_DONE : ST_DIFF;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = idx_r;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // fetch vertex j of the first edge: the last stored vertex
        rd_en    = in_acc && is_query;
        rd_addr  = count_m1[IdxW-1:0];
      end
      ST_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      ST_DIFF: begin
        rd_en   = !last_edge;
        rd_addr = idx_r + IdxW'(1);
      end
      ST_DONE:  load_out = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Shared multiplier: first product in MUL_P, second in MUL_Q
  assign mul_a = (state_r == ST_MUL_Q) ? c_mag_r : a_mag_r;
  assign mul_b = (state_r == ST_MUL_Q) ? d_mag_r : b_mag_r;
  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  assign dif_a = DiffW'(px_r) - DiffW'(rd_x_r);
  assign dif_b = DiffW'(yj_r) - DiffW'(rd_y_r);
  assign dif_c = DiffW'(xj_r) - DiffW'(rd_x_r);
  assign dif_d = DiffW'(py_r) - DiffW'(rd_y_r);

  // Sign of a*b - c*d from magnitudes and signs
  always_comb begin
    p_neg = (p_r != '0) && (a_neg_r != b_neg_r);
    q_neg = (q_r != '0) && (c_neg_r != d_neg_r);
    if (p_neg != q_neg) begin
      p_gt_q = !p_neg;
      p_eq_q = 1'b0;
    end else begin
      p_eq_q = p_r == q_r;
      p_gt_q = p_neg ? (p_r < q_r) : (p_r > q_r);
    end
    // the sense of the compare follows the sign of dy
    edge_hit = dy_pos_r ? !p_gt_q : (p_gt_q || p_eq_q);
  end

  // Datapath next values
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    inside_nxt    = inside_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    xj_nxt        = xj_r;
    yj_nxt        = yj_r;
    a_mag_nxt     = a_mag_r;
    b_mag_nxt     = b_mag_r;
    c_mag_nxt     = c_mag_r;
    d_mag_nxt     = d_mag_r;
    a_neg_nxt     = a_neg_r;
    b_neg_nxt     = b_neg_r;
    c_neg_nxt     = c_neg_r;
    d_neg_nxt     = d_neg_r;
    cross_nxt     = cross_r;
    dy_pos_nxt    = dy_pos_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_clear) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else if (is_append) begin
            if (count_r < CntW'(MaxVertices)) begin
              count_nxt = count_r + CntW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (is_query) begin
            px_nxt     = in_beat.coord_x;
            py_nxt     = in_beat.coord_y;
            inside_nxt = 1'b0;
            idx_nxt    = '0;
          end
        end
      end
      ST_PRIME: begin
        xj_nxt = rd_x_r;
        yj_nxt = rd_y_r;
      end
      ST_DIFF: begin
        a_mag_nxt  = mag_of(dif_a);
        b_mag_nxt  = mag_of(dif_b);
        c_mag_nxt  = mag_of(dif_c);
        d_mag_nxt  = mag_of(dif_d);
        a_neg_nxt  = dif_a[DiffW-1];
        b_neg_nxt  = dif_b[DiffW-1];
        c_neg_nxt  = dif_c[DiffW-1];
        d_neg_nxt  = dif_d[DiffW-1];
        dy_pos_nxt = !dif_b[DiffW-1] && (dif_b != '0);
        cross_nxt  = (rd_y_r >= py_r) != (yj_r >= py_r);
        // vertex i becomes vertex j of the next edge
        xj_nxt     = rd_x_r;
        yj_nxt     = rd_y_r;
      end
      ST_MUL_P: p_nxt = mul_p;
      ST_MUL_Q: q_nxt = mul_p;
      ST_CMP: begin
        if (cross_r && edge_hit) begin
          inside_nxt = !inside_r;
        end
        idx_nxt = idx_r + IdxW'(1);
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt                 = 1'b1;
          out_beat_nxt.inside_res       = inside_r;
          out_beat_nxt.stop_command     = !inside_r;
          out_beat_nxt.vertices_dropped = ovf_r;
        end
      end
      default: begin
        inside_nxt = inside_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    inside_r   <= inside_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    xj_r       <= xj_nxt;
    yj_r       <= yj_nxt;
    a_mag_r    <= a_mag_nxt;
    b_mag_r    <= b_mag_nxt;
    c_mag_r    <= c_mag_nxt;
    d_mag_r    <= d_mag_nxt;
    a_neg_r    <= a_neg_nxt;
    b_neg_r    <= b_neg_nxt;
    c_neg_r    <= c_neg_nxt;
    d_neg_r    <= d_neg_nxt;
    cross_r    <= cross_nxt;
    dy_pos_r   <= dy_pos_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    out_beat_r <= out_beat_nxt;
  end

  // Vertex store: write on an append that fits, registered read
  always_ff @(posedge clk) begin
    if (in_acc && is_append && (count_r < CntW'(MaxVertices))) begin
      mem_x[count_r[IdxW-1:0]] <= in_beat.coord_x;
      mem_y[count_r[IdxW-1:0]] <= in_beat.coord_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

`default_nettype wire
